// ===== design/hsort_pkg.sv =====
package hsort_pkg;

  // Sequencer states: take items into the row, then stream the row out
  typedef enum logic [0:0] {
    ST_LOAD,
    ST_DRAIN
  } hsort_state_t;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic insert;  // place the broadcast value into the sorted row
    logic shift;   // move every cell one place toward the head
  } cell_ctrl_t;

endpackage

// ===== design/hsort_if.sv =====
interface hsort_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface hsort_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sorted_value;
  logic                         end_of_set;
  logic                         overflowed;

  modport source (output valid, output sorted_value, output end_of_set,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input end_of_set,
                  input overflowed, output ready);
endinterface

// ===== design/hsort_cell.sv =====
module hsort_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  hsort_pkg::cell_ctrl_t        ctrl,
  input  logic                         occ,
  input  logic signed [DATA_WIDTH-1:0] in_val,
  input  logic signed [DATA_WIDTH-1:0] left_val,
  input  logic                         left_take,
  input  logic signed [DATA_WIDTH-1:0] right_val,
  output logic signed [DATA_WIDTH-1:0] val_o,
  output logic                         take_o
);
  import hsort_pkg::*;

  logic signed [DATA_WIDTH-1:0] val_r;
  logic signed [DATA_WIDTH-1:0] val_nxt;

  // An empty cell counts as larger than anything
  assign take_o = !occ || (in_val < val_r);
  assign val_o  = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.insert && take_o) begin
      // Left neighbor also moves aside: take its value, else take the new one
      val_nxt = left_take ? left_val : in_val;
    end else if (ctrl.shift) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== design/heap_sort_engine.sv =====
// Channel   Dir  Handshake        Payload
// in_ch     in   valid / ready    value, is_last
// out_ch    out  valid / ready    sorted_value, end_of_set, overflowed
//
// Loading takes one item per cycle: the value is broadcast to a row of
// MAX_ITEMS cells that keeps the set sorted ascending, and every cell settles
// in the same cycle from its own compare and its left neighbor's.
// An item with is_last switches to draining: the stored values leave one per
// cycle while out_ch.ready is high, smallest first, and in_ch.ready
// stays low meanwhile. A stalled result simply holds in the head cell.
// Reset (rst_n low, synchronous) empties the set; no clearing pass is needed.
module heap_sort_engine #(
  parameter int MAX_ITEMS  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  hsort_in_if.sink           in_ch,
  hsort_out_if.source        out_ch
);
  import hsort_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  hsort_state_t state_r;
  hsort_state_t state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             dropped_r;
  logic             dropped_nxt;

  logic       in_acc;
  logic       out_acc;
  logic       full;
  cell_ctrl_t ctrl;

  logic signed [DATA_WIDTH-1:0] val_w  [MAX_ITEMS];
  logic                         take_w [MAX_ITEMS];

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign full    = (count_r == CNT_W'(MAX_ITEMS));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_ch.is_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc && (count_r == CNT_W'(1))) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    ctrl.insert  = 1'b0;
    ctrl.shift   = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ch.ready = 1'b1;
        ctrl.insert = in_ch.valid && !full;
      end
      ST_DRAIN: begin
        out_ch.valid = 1'b1;
        ctrl.shift   = out_ch.ready;
      end
      default: begin
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
      end
    endcase
  end

  // Count of held values; during draining it counts what is left to send
  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    if (in_acc) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
    if (out_acc) begin
      count_nxt = count_r - CNT_W'(1);
      if (count_r == CNT_W'(1)) begin
        dropped_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // Row of sorting cells, head (smallest) at index 0
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_val;
    logic                         left_take;
    logic signed [DATA_WIDTH-1:0] right_val;

    if (i == 0) begin : g_head
      assign left_val  = in_ch.value;
      assign left_take = 1'b0;
    end else begin : g_body
      assign left_val  = val_w[i-1];
      assign left_take = take_w[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_mid
      assign right_val = val_w[i+1];
    end

    hsort_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (CNT_W'(i) < count_r),
      .in_val    (in_ch.value),
      .left_val  (left_val),
      .left_take (left_take),
      .right_val (right_val),
      .val_o     (val_w[i]),
      .take_o    (take_w[i])
    );
  end

  // Head cell holds the next result
  assign out_ch.sorted_value = val_w[0];
  assign out_ch.end_of_set   = (count_r == CNT_W'(1));
  assign out_ch.overflowed   = dropped_r;

  // Never exceed the row
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS))
    else $error("held count exceeds capacity");

  // Draining always has something to send
  a_drain_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (count_r != '0))
    else $error("draining with an empty row");

  // A last item starts the output run in the next cycle
  a_last_starts_drain : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.is_last) |=> out_ch.valid)
    else $error("last item did not start output");

  // After the final result the set is empty and clean
  a_run_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.end_of_set) |=> (count_r == '0 && !dropped_r && in_ch.ready))
    else $error("set not cleared after final result");

  // An item taken while full leaves the count alone and marks the set
  a_drop_marks : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full) |=> (dropped_r && $stable(count_r)))
    else $error("dropped item not recorded");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int MAX_ITEMS    = 64;
  localparam int DATA_WIDTH   = 32;
  localparam int RANDOM_ITEMS = 450;
  localparam int LONG_HOLD    = 400;  // receiver stall long enough to back up the input
  localparam int DRAIN_SLACK  = 20;   // quiet cycles after the last result
  localparam int REPORT_LIMIT = 10;

  localparam logic signed [DATA_WIDTH-1:0] V_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] V_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // One item of the result channel
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         end_of_set;
    logic                         overflowed;
  } sorted_result_t;

  // One row of the directed table; typed rows carry their own single result
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         is_last;
    bit                           typed;
    sorted_result_t               want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  hsort_in_if  #(.DATA_WIDTH(DATA_WIDTH)) in_ch ();
  hsort_out_if #(.DATA_WIDTH(DATA_WIDTH)) out_ch ();

  heap_sort_engine #(
    .MAX_ITEMS (MAX_ITEMS),
    .DATA_WIDTH(DATA_WIDTH)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Predictor state: the current set kept in ascending order, plus drop flag
  logic signed [DATA_WIDTH-1:0] held_set[$];
  bit                           set_dropped;

  // Results still owed by the block, oldest first
  sorted_result_t expected_results[$];

  stim_row_t directed_rows[$];

  int  fault_count;
  int  results_seen;
  bit  tx_steady;
  bit  rx_steady;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Insert one value into the set (or drop it when full); on the last item
  // of a set queue every held value in ascending order and clear the set.
  task automatic order_value(input logic signed [DATA_WIDTH-1:0] v, input logic last);
    int pos;
    sorted_result_t r;
    if (held_set.size() < MAX_ITEMS) begin
      pos = 0;
      while (pos < held_set.size() && held_set[pos] <= v) pos++;
      held_set.insert(pos, v);
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      foreach (held_set[k]) begin
        r.value      = held_set[k];
        r.end_of_set = (k == held_set.size() - 1);
        r.overflowed = set_dropped;
        expected_results.push_back(r);
      end
      held_set.delete();
      set_dropped = 1'b0;
    end
  endtask

  // Offer one item after a random gap and hold it until it is accepted.
  // Lower valid only when a gap follows, so a back-to-back item never sees
  // valid dropped and raised in the same step.
  task automatic offer_item(input logic signed [DATA_WIDTH-1:0] v, input logic last,
                            input bit typed, input sorted_result_t want);
    int gap;
    int depth_before;
    if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= v;
    in_ch.is_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // Item taken at this edge: update the prediction
    depth_before = expected_results.size();
    order_value(v, last);
    if (typed) begin
      // Replace the predicted result with the one written in the table
      while (expected_results.size() > depth_before) void'(expected_results.pop_back());
      expected_results.push_back(want);
    end
  endtask

  task automatic add_row(input logic signed [DATA_WIDTH-1:0] v, input logic last,
                         input bit typed, input logic signed [DATA_WIDTH-1:0] want_value,
                         input logic want_eos, input logic want_ovf);
    stim_row_t row;
    row.value           = v;
    row.is_last         = last;
    row.typed           = typed;
    row.want.value      = want_value;
    row.want.end_of_set = want_eos;
    row.want.overflowed = want_ovf;
    directed_rows.push_back(row);
  endtask

  // Mix extremes, a narrow band (for duplicates) and full-range values
  function automatic logic signed [DATA_WIDTH-1:0] draw_value();
    case ($urandom_range(0, 9))
      0:       draw_value = V_MAX;
      1:       draw_value = V_MIN;
      2, 3:    draw_value = $urandom_range(0, 16) - 8;
      default: draw_value = $urandom;
    endcase
  endfunction

  // Sender: reset, directed table, random sets, then the end of the run
  initial begin
    int set_idx;
    int set_len;
    int sent;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.is_last = 1'b0;
    fault_count   = 0;
    set_dropped   = 1'b0;
    tx_steady     = 1'b0;

    // Single-item sets: the result is the value itself, flagged last
    add_row(V_MAX, 1'b1, 1'b1, V_MAX, 1'b1, 1'b0);
    add_row(V_MIN, 1'b1, 1'b1, V_MIN, 1'b1, 1'b0);
    add_row(0,     1'b1, 1'b1, 0,     1'b1, 1'b0);
    add_row(-1,    1'b1, 1'b1, -1,    1'b1, 1'b0);
    // Mixed signs, both extremes and duplicates in one set
    add_row(5,     1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(-3,    1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(V_MAX, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(V_MIN, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(0,     1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(5,     1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(-3,    1'b1, 1'b0, 0, 1'b0, 1'b0);
    // Descending input: every insert moves to the front
    add_row(40,    1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(30,    1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(20,    1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(10,    1'b1, 1'b0, 0, 1'b0, 1'b0);
    // Ascending input with runs of equal values
    add_row(-2,    1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(-2,    1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(-1,    1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(-1,    1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(7,     1'b1, 1'b0, 0, 1'b0, 1'b0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_item(directed_rows[i].value, directed_rows[i].is_last,
                 directed_rows[i].typed, directed_rows[i].want);

    // Random sets: mostly short, one that overflows (last item dropped),
    // one that fills the set exactly
    set_idx = 0;
    sent    = 0;
    while (sent < RANDOM_ITEMS) begin
      if (set_idx == 2)
        set_len = MAX_ITEMS + $urandom_range(1, 3);
      else if (set_idx == 5)
        set_len = MAX_ITEMS;
      else if ($urandom_range(0, 6) == 0)
        set_len = $urandom_range(11, 40);
      else
        set_len = $urandom_range(1, 10);

      // Pause the sender once until every owed result has come back
      if (set_idx == 8) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
      end

      for (int k = 0; k < set_len; k++)
        offer_item(draw_value(), k == set_len - 1, 1'b0, '0);
      sent += set_len;
      set_idx++;
    end

    // Drop valid, drain the owed results, then watch for strays
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);

    if (fault_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Receiver: random back-pressure, one long hold, and the result check
  initial begin
    int gap;
    sorted_result_t got;
    sorted_result_t want;
    bit long_hold_done;
    out_ch.ready   = 1'b0;
    results_seen   = 0;
    rx_steady      = 1'b0;
    long_hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 6);
      // Hold off once for a long stretch while the sender keeps offering
      if (results_seen == 40 && !long_hold_done) begin
        gap            = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);

      got.value      = out_ch.sorted_value;
      got.end_of_set = out_ch.end_of_set;
      got.overflowed = out_ch.overflowed;
      if (expected_results.size() == 0) begin
        if (fault_count < REPORT_LIMIT)
          $display("result %0d: unexpected item value=%0d eos=%0b ovf=%0b",
                   results_seen, $signed(got.value), got.end_of_set, got.overflowed);
        fault_count++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          if (fault_count < REPORT_LIMIT)
            $display("result %0d: got value=%0d eos=%0b ovf=%0b, want value=%0d eos=%0b ovf=%0b",
                     results_seen, $signed(got.value), got.end_of_set, got.overflowed,
                     $signed(want.value), want.end_of_set, want.overflowed);
          fault_count++;
        end
      end
      results_seen++;
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== heap_sort_engine.f =====
design/hsort_pkg.sv
design/hsort_if.sv
design/hsort_cell.sv
design/heap_sort_engine.sv
test/tb.sv
